// File: rtl/ten_pkg.sv
package ten_pkg;

    localparam logic [7:0] C_QMARK = 8'h3F;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_NONE  = 8'h00;

    localparam logic [1:0] C_HELD_ONE = 2'd1;
    localparam logic [1:0] C_HELD_TWO = 2'd2;
    localparam logic [1:0] C_HELD_BAD = 2'd3;

    typedef struct packed {
        logic [1:0] held;
        logic       drop_lf;
        logic       seen;
        logic       last_lf;
    } t_state;

    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
    } t_burst;

    function automatic logic [7:0] ten_trigraph_map(input logic [7:0] c);
        logic [7:0] m;
        unique case (c)
            8'h3D:   m = 8'h23;
            8'h28:   m = 8'h5B;
            8'h2F:   m = 8'h5C;
            8'h29:   m = 8'h5D;
            8'h27:   m = 8'h5E;
            8'h3C:   m = 8'h7B;
            8'h21:   m = 8'h7C;
            8'h3E:   m = 8'h7D;
            8'h2D:   m = 8'h7E;
            default: m = C_NONE;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/trigraph_eol_normalizer_top.sv
// Streaming trigraph replacement and line-end normalization for C source text.
// One byte enters per transfer and yields zero to three output bytes; a text
// is closed by an item with i_end_of_text set, which flushes held '?' bytes,
// appends a final LF when needed and returns all state to reset. Each item is
// registered, expanded combinationally and loaded into a three-byte output
// burst register; one item is taken per cycle while each item yields at most
// one byte and the output is not stalled. The single output port sets the
// rate: an item that yields more than one byte holds the input through
// o_stall until its burst is down to its last byte.
module trigraph_eol_normalizer_top
    import ten_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_last
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_end;
    t_state          r_st;
    logic [1:0]      r_cnt;
    logic [2:0][7:0] r_bytes;
    logic            r_burst_end;

    logic            n_in_valid;
    t_state          n_st;
    logic [1:0]      n_cnt;
    logic [2:0][7:0] n_bytes;
    logic            n_burst_end;

    logic            burst_free;
    logic            adv;
    logic            in_take;
    logic            out_take;
    logic            load;
    t_burst          step_res;
    t_state          step_st;

    ten_step u_step (
        .i_byte (r_in_byte),
        .i_end  (r_in_end),
        .i_st   (r_st),
        .o_res  (step_res),
        .o_st   (step_st)
    );

    assign o_valid     = (r_cnt != 2'd0);
    assign o_out_byte  = r_bytes[0];
    assign o_run_last  = (r_cnt == 2'd1);
    assign o_text_last = (r_cnt == 2'd1) && r_burst_end;

    assign out_take   = o_valid && !i_stall;
    assign burst_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall);
    assign adv        = r_in_valid && burst_free;
    assign o_stall    = r_in_valid && !burst_free;
    assign in_take    = i_valid && !o_stall;
    assign load       = adv && (step_res.cnt != 2'd0);

    always_comb begin
        n_in_valid  = in_take ? 1'b1 : (adv ? 1'b0 : r_in_valid);
        n_st        = adv ? step_st : r_st;
        n_cnt       = r_cnt;
        n_bytes     = r_bytes;
        n_burst_end = r_burst_end;
        if (load) begin
            n_cnt       = step_res.cnt;
            n_bytes     = step_res.bytes;
            n_burst_end = r_in_end;
        end else if (out_take) begin
            n_cnt   = r_cnt - 2'd1;
            n_bytes = {8'h00, r_bytes[2], r_bytes[1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= '0;
            r_cnt      <= 2'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_st       <= n_st;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_end_of_text;
        end
        r_bytes     <= n_bytes;
        r_burst_end <= n_burst_end;
    end

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.held != C_HELD_BAD)
        else $error("held question mark count out of range");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_end) |=> (r_st == '0))
        else $error("state not cleared after end of text");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall)))
        else $error("burst loaded over pending output");

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_end)))
        else $error("held input item lost");

endmodule

// File: rtl/ten_step.sv
module ten_step
    import ten_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  t_state     i_st,
    output t_burst     o_res,
    output t_state     o_st
);

    logic [1:0]      held;
    logic [1:0]      n_held;
    logic [7:0]      map;
    logic [2:0][7:0] s1;
    logic [1:0]      s1_cnt;
    logic [2:0][7:0] ob;
    logic [1:0]      ocnt;
    logic            drop;
    logic            seen;
    logic            lf;
    logic            need_lf;
    logic [7:0]      c;

    always_comb begin
        held   = (i_st.held == C_HELD_BAD) ? C_HELD_TWO : i_st.held;
        map    = ten_trigraph_map(i_byte);
        s1     = '0;
        s1_cnt = 2'd0;
        n_held = 2'd0;

        if (held == C_HELD_TWO) begin
            if (map != C_NONE) begin
                s1[0]  = map;
                s1_cnt = 2'd1;
            end else if (i_byte == C_QMARK) begin
                s1[0]  = C_QMARK;
                s1_cnt = 2'd1;
                n_held = C_HELD_TWO;
            end else begin
                s1[0]  = C_QMARK;
                s1[1]  = C_QMARK;
                s1[2]  = i_byte;
                s1_cnt = 2'd3;
            end
        end else if (held == C_HELD_ONE) begin
            if (i_byte == C_QMARK) begin
                n_held = C_HELD_TWO;
            end else begin
                s1[0]  = C_QMARK;
                s1[1]  = i_byte;
                s1_cnt = 2'd2;
            end
        end else begin
            if (i_byte == C_QMARK) begin
                n_held = C_HELD_ONE;
            end else begin
                s1[0]  = i_byte;
                s1_cnt = 2'd1;
            end
        end

        // line-end stage over the expanded bytes
        drop = i_st.drop_lf;
        seen = i_st.seen;
        lf   = i_st.last_lf;
        ob   = '0;
        ocnt = 2'd0;
        c    = C_NONE;
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < s1_cnt) begin
                c = s1[k];
                if (c == C_CR) begin
                    ob[ocnt] = C_LF;
                    ocnt     = ocnt + 2'd1;
                    drop     = 1'b1;
                    seen     = 1'b1;
                    lf       = 1'b1;
                end else if (c == C_LF && drop) begin
                    drop = 1'b0;
                end else begin
                    ob[ocnt] = c;
                    ocnt     = ocnt + 2'd1;
                    drop     = 1'b0;
                    seen     = 1'b1;
                    lf       = (c == C_LF);
                end
            end
        end

        need_lf = (held != 2'd0) || (i_st.seen && !i_st.last_lf);

        if (i_end) begin
            ob   = '0;
            if (held != 2'd0) begin
                ob[0] = C_QMARK;
            end
            if (held == C_HELD_TWO) begin
                ob[1] = C_QMARK;
            end
            if (need_lf) begin
                ob[held] = C_LF;
            end
            o_res.cnt   = held + {1'b0, need_lf};
            o_res.bytes = ob;
            o_st        = '0;
        end else begin
            o_res.cnt    = ocnt;
            o_res.bytes  = ob;
            o_st.held    = n_held;
            o_st.drop_lf = drop;
            o_st.seen    = seen;
            o_st.last_lf = lf;
        end
    end

endmodule

// File: bench/trigraph_eol_normalizer_top_test.sv
module trigraph_eol_normalizer_top_test;
    import ten_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 460;
    localparam int LONG_HOLD = 120;
    localparam int MAX_WAIT = 17;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_last;
    } due_byte_t;

    class normalized_byte_tracker;
        due_byte_t  due_bytes[$];
        logic [7:0] produced[$];
        logic [1:0] held;
        logic       drop_lf;
        logic       seen;
        logic       last_lf;
        int         mismatches;

        function new();
            mismatches = 0;
            clear_text();
        endfunction

        function void clear_text();
            held    = '0;
            drop_lf = 1'b0;
            seen    = 1'b0;
            last_lf = 1'b0;
        endfunction

        function logic [7:0] trigraph_of(logic [7:0] c);
            case (c)
                8'h3D:   return 8'h23;
                8'h28:   return 8'h5B;
                8'h2F:   return 8'h5C;
                8'h29:   return 8'h5D;
                8'h27:   return 8'h5E;
                8'h3C:   return 8'h7B;
                8'h21:   return 8'h7C;
                8'h3E:   return 8'h7D;
                8'h2D:   return 8'h7E;
                default: return C_NONE;
            endcase
        endfunction

        // CR and CRLF collapse to a single LF
        function void line_out(logic [7:0] c);
            logic [7:0] o;
            if (c == C_CR) begin
                o = C_LF;
                drop_lf = 1'b1;
            end else if (c == C_LF && drop_lf) begin
                drop_lf = 1'b0;
                return;
            end else begin
                o = c;
                drop_lf = 1'b0;
            end
            produced = {produced, o};
            seen    = 1'b1;
            last_lf = (o == C_LF);
        endfunction

        function void take_source_byte(logic [7:0] b, logic eot);
            logic [1:0] h;
            logic [7:0] m;
            due_byte_t  d;
            produced.delete();
            h = (held == C_HELD_BAD) ? C_HELD_TWO : held;
            m = trigraph_of(b);
            if (eot) begin
                repeat (h) line_out(C_QMARK);
                if (seen && !last_lf) line_out(C_LF);
                clear_text();
            end else if (h == C_HELD_TWO) begin
                if (m != C_NONE) begin
                    line_out(m);
                    held = '0;
                end else if (b == C_QMARK) begin
                    line_out(C_QMARK);
                    held = C_HELD_TWO;
                end else begin
                    line_out(C_QMARK);
                    line_out(C_QMARK);
                    line_out(b);
                    held = '0;
                end
            end else if (h == C_HELD_ONE) begin
                if (b == C_QMARK) begin
                    held = C_HELD_TWO;
                end else begin
                    line_out(C_QMARK);
                    line_out(b);
                    held = '0;
                end
            end else if (b == C_QMARK) begin
                held = C_HELD_ONE;
            end else begin
                line_out(b);
            end
            foreach (produced[k]) begin
                d.data      = produced[k];
                d.run_last  = (k == produced.size() - 1);
                d.text_last = d.run_last && eot;
                due_bytes = {due_bytes, d};
            end
        endfunction

        function void match_output_byte(logic [7:0] data, logic run_last, logic text_last);
            due_byte_t e;
            if (due_bytes.size() == 0) begin
                $error("unexpected transfer: out_byte=%h run_last=%b text_last=%b",
                       data, run_last, text_last);
                mismatches++;
                return;
            end
            e = due_bytes.pop_front();
            if (e.data !== data) begin
                $error("out_byte: expected %h, got %h", e.data, data);
                mismatches++;
            end
            if (e.run_last !== run_last) begin
                $error("run_last: expected %b, got %b", e.run_last, run_last);
                mismatches++;
            end
            if (e.text_last !== text_last) begin
                $error("text_last: expected %b, got %b", e.text_last, text_last);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_end_of_text;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_text_last;

    normalized_byte_tracker tracker;
    int cycle_count;
    bit tx_quiet;
    bit rx_quiet;
    bit hold_rx;

    trigraph_eol_normalizer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_text_last   (o_text_last)
    );

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in_byte     = '0;
        i_end_of_text = 1'b0;
        i_stall       = 1'b0;
        cycle_count   = 0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        hold_rx       = 1'b0;
        tracker       = new();
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [7:0] trigraph_key(int i);
        case (i)
            0:       return 8'h3D;
            1:       return 8'h28;
            2:       return 8'h2F;
            3:       return 8'h29;
            4:       return 8'h27;
            5:       return 8'h3C;
            6:       return 8'h21;
            7:       return 8'h3E;
            default: return 8'h2D;
        endcase
    endfunction

    // called and returns at a falling edge where i_valid is not yet assigned
    task automatic send_item(input logic [7:0] b, input logic eot);
        int gap;
        i_valid       <= 1'b1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_stall);
        tracker.take_source_byte(b, eot);
        @(negedge i_clk);
        gap = draw_wait(tx_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tracker.due_bytes.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] mixed_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) return trigraph_key($urandom_range(0, 8));
        if (pick == 3) return C_CR;
        if (pick == 4) return C_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random(input int count);
        int sent;
        int kind;
        int k;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                send_item(C_QMARK, 1'b0);
                send_item(C_QMARK, 1'b0);
                send_item(trigraph_key($urandom_range(0, 8)), 1'b0);
                sent += 3;
            end else if (kind < 35) begin
                k = $urandom_range(1, 5);
                repeat (k) send_item(C_QMARK, 1'b0);
                send_item(mixed_byte(), 1'b0);
                sent += k + 1;
            end else if (kind < 45) begin
                send_item(C_CR, 1'b0);
                send_item(C_LF, 1'b0);
                sent += 2;
            end else if (kind < 52) begin
                send_item(C_CR, 1'b0);
                sent++;
            end else if (kind < 57) begin
                send_item(C_LF, 1'b0);
                sent++;
            end else if (kind < 63) begin
                send_item(8'($urandom_range(0, 255)), 1'b1);
                sent++;
            end else if (kind < 75) begin
                send_item(C_QMARK, 1'b0);
                sent++;
            end else begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
                sent++;
            end
        end
    endtask

    initial begin : receiver
        int n;
        @(negedge i_clk);
        forever begin
            if (hold_rx) begin
                hold_rx = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                n = draw_wait(rx_quiet);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(negedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            tracker.match_output_byte(o_out_byte, o_run_last, o_text_last);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty text, byte extremes
        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(C_QMARK, 1'b0);
        send_item(C_QMARK, 1'b0);
        send_item(8'h3D, 1'b0);
        // surplus question marks shift the window
        repeat (4) send_item(C_QMARK, 1'b0);
        send_item(8'h2D, 1'b0);
        send_item(C_QMARK, 1'b0);
        send_item(C_CR, 1'b0);
        send_item(C_LF, 1'b0);
        send_item(C_QMARK, 1'b0);
        send_item(C_QMARK, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h5A, 1'b1);
        // text already ending in LF closes silently
        send_item(C_LF, 1'b0);
        send_item(8'hC3, 1'b1);
        send_item(C_QMARK, 1'b0);
        send_item(C_QMARK, 1'b0);
        send_item(8'hA5, 1'b1);
        wait_drained();
        @(negedge i_clk);

        send_random(RANDOM_ITEMS / 4);
        wait_drained();
        @(negedge i_clk);

        // full rate against a long output hold
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        hold_rx  = 1'b1;
        send_random(RANDOM_ITEMS / 4);

        tx_quiet = 1'b0;
        send_random(RANDOM_ITEMS / 4);

        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        send_random(RANDOM_ITEMS / 4);
        tx_quiet = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (tracker.mismatches == 0 && tracker.due_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
